// ===== rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, sizes and helper functions of the bit stream compactor.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int WORD_BITS  = 64;
    localparam int COUNT_BITS = 32;
    localparam int CNT_W      = $clog2(WORD_BITS);
    localparam int NB_W       = $clog2(WORD_BITS + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int LIMIT_W    = 32;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [ADDR_W-3:0] REG_DST_LIMIT = '0;

    typedef struct packed {
        logic [WORD_BITS-1:0] src_word;
        logic [WORD_BITS-1:0] select_word;
        logic [6:0]           valid_bits;
        logic                 last_item;
    } item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]  packed_word;
        logic [6:0]            word_bits;
        logic                  last_word;
        logic [COUNT_BITS-1:0] total_bits;
    } result_t;

    function automatic logic [WORD_BITS-1:0] mask_low(input logic [NB_W-1:0] n);
        logic [WORD_BITS-1:0] m;
        if (n >= NB_W'(WORD_BITS))
            m = '1;
        else
            m = (WORD_BITS'(1) << n) - WORD_BITS'(1);
        return m;
    endfunction

    // balanced adder tree
    function automatic logic [NB_W-1:0] pop_count(input logic [WORD_BITS-1:0] v);
        logic [NB_W-1:0] part [WORD_BITS];
        for (int i = 0; i < WORD_BITS; i++)
        begin
            part[i] = NB_W'(v[i]);
        end
        for (int s = 1; s < WORD_BITS; s = s * 2)
        begin
            for (int i = 0; i + s < WORD_BITS; i = i + 2 * s)
            begin
                part[i] = part[i] + part[i + s];
            end
        end
        return part[0];
    endfunction

endpackage

// ===== rtl/bit_stream_compactor.sv =====
// ----------------------------------------------------------------------------
// bit_stream_compactor
// Streaming parallel bit extract: packs selected source bits into full words.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall / item, one source word and its
//                    select mask per item; last_item closes an array
//   result channel : result_valid / result_stall / result, full 64-bit packed
//                    words, then a flush word with last_word set on the last item
//   apb port       : dst_limit_bits at byte address 0, readable and writable
//   path           : an item passes the input register, the extract register
//                    and the result register before its result is shown
//   throughput     : one item per cycle while the result is not stalled; an
//                    item that yields both a full word and a flush word holds
//                    the input until the flush moves from out1 to the port
//   reset          : accumulator, counts and all pipeline valids clear, the
//                    limit returns to all-ones
//   stall          : a stalled result holds; the pipeline keeps filling its
//                    two stages, then raises item_stall
// ----------------------------------------------------------------------------
module bit_stream_compactor (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  bsc_pkg::item_t           item,
    output logic                     result_valid,
    input  logic                     result_stall,
    output bsc_pkg::result_t         result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [bsc_pkg::ADDR_W-1:0] paddr,
    input  logic [bsc_pkg::DATA_W-1:0] pwdata,
    output logic [bsc_pkg::DATA_W-1:0] prdata,
    output logic                     pready
);
    import bsc_pkg::*;

    logic                   s1_v_reg;
    item_t                  s1_reg;
    logic                   s2_v_reg;
    logic [WORD_BITS-1:0]   s2_pext_reg;
    logic [NB_W-1:0]        s2_cnt_reg;
    logic                   s2_last_reg;

    logic [WORD_BITS-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]  emitted_reg, emitted_next;
    logic [LIMIT_W-1:0]     limit_reg;

    logic                   out0_v_reg, out0_v_next;
    logic                   out1_v_reg, out1_v_next;
    result_t                out0_reg, out0_next;
    result_t                out1_reg, out1_next;

    logic                   out_take;
    logic                   can_merge;
    logic                   merge;
    logic                   s2_ready;
    logic                   s1_ready;
    logic                   cfg_write;

    // extract
    logic [NB_W-1:0]        nvalid;
    logic [WORD_BITS-1:0]   sel_m;
    logic [WORD_BITS-1:0]   dat [SUM_W];
    logic [CNT_W-1:0]       tag [SUM_W][WORD_BITS];
    logic [WORD_BITS-1:0]   pext;
    logic [NB_W-1:0]        sel_cnt;

    // merge
    logic [LIMIT_W:0]       room_wide;
    logic [LIMIT_W-1:0]     room;
    logic [NB_W-1:0]        kept;
    logic [WORD_BITS-1:0]   pv;
    logic [2*WORD_BITS-1:0] wide;
    logic [SUM_W-1:0]       sum;
    logic                   full;
    logic [WORD_BITS-1:0]   acc_rem;
    logic [COUNT_BITS-1:0]  emitted_add;
    result_t                res_full;
    result_t                res_flush;

    assign out_take  = out0_v_reg & ~result_stall;
    assign can_merge = ~out1_v_reg & (~out0_v_reg | out_take);
    assign merge     = s2_v_reg & can_merge;
    assign s2_ready  = ~s2_v_reg | can_merge;
    assign s1_ready  = ~s1_v_reg | s2_ready;
    assign item_stall = ~s1_ready;

    assign result_valid = out0_v_reg;
    assign result       = out0_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[ADDR_W-1:2] == REG_DST_LIMIT) ? DATA_W'(limit_reg) : '0;

    // compress selected bits toward bit 0, by the count of unselected bits below
    always_comb
    begin
        nvalid  = (s1_reg.valid_bits > 7'(WORD_BITS)) ? NB_W'(WORD_BITS)
                                                       : NB_W'(s1_reg.valid_bits);
        sel_m   = s1_reg.select_word & mask_low(nvalid);
        sel_cnt = pop_count(sel_m);
        dat[0]  = s1_reg.src_word & sel_m;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            tag[0][i] = sel_m[i] ? CNT_W'(pop_count(~sel_m & mask_low(NB_W'(i)))) : '0;
        end
        for (int k = 0; k < CNT_W; k++)
        begin
            for (int p = 0; p < WORD_BITS; p++)
            begin
                dat[k+1][p] = dat[k][p] & ~tag[k][p][k];
                tag[k+1][p] = tag[k][p][k] ? '0 : tag[k][p];
                if (p + (1 << k) < WORD_BITS)
                begin
                    if (tag[k][p + (1 << k)][k])
                    begin
                        dat[k+1][p] = dat[k+1][p] | dat[k][p + (1 << k)];
                        tag[k+1][p] = tag[k+1][p] | tag[k][p + (1 << k)];
                    end
                end
            end
        end
        pext = dat[CNT_W];
    end

    // merge into the accumulator against the limit
    always_comb
    begin
        room_wide   = {1'b0, limit_reg} - {1'b0, emitted_reg};
        room        = room_wide[LIMIT_W] ? '0 : room_wide[LIMIT_W-1:0];
        kept        = (room < LIMIT_W'(s2_cnt_reg)) ? room[NB_W-1:0] : s2_cnt_reg;
        pv          = s2_pext_reg & mask_low(kept);
        wide        = {{WORD_BITS{1'b0}}, acc_reg} | ({{WORD_BITS{1'b0}}, pv} << cnt_reg);
        sum         = SUM_W'(cnt_reg) + SUM_W'(kept);
        full        = sum[CNT_W];
        acc_rem     = full ? wide[2*WORD_BITS-1:WORD_BITS] : wide[WORD_BITS-1:0];
        emitted_add = emitted_reg + COUNT_BITS'(kept);

        res_full.packed_word = wide[WORD_BITS-1:0];
        res_full.word_bits   = 7'(WORD_BITS);
        res_full.last_word   = 1'b0;
        res_full.total_bits  = emitted_reg
                             + COUNT_BITS'(NB_W'(WORD_BITS) - NB_W'(cnt_reg));

        res_flush.packed_word = acc_rem;
        res_flush.word_bits   = 7'(sum[CNT_W-1:0]);
        res_flush.last_word   = 1'b1;
        res_flush.total_bits  = emitted_add;

        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        emitted_next = emitted_reg;
        if (merge)
        begin
            if (s2_last_reg)
            begin
                acc_next     = '0;
                cnt_next     = '0;
                emitted_next = '0;
            end
            else
            begin
                acc_next     = acc_rem;
                cnt_next     = sum[CNT_W-1:0];
                emitted_next = emitted_add;
            end
        end
    end

    // two result slots: out0 drives the port, out1 holds the flush behind a full word
    always_comb
    begin
        out0_v_next = out0_v_reg;
        out1_v_next = out1_v_reg;
        out0_next   = out0_reg;
        out1_next   = out1_reg;
        if (out_take)
        begin
            out0_v_next = out1_v_reg;
            out0_next   = out1_reg;
            out1_v_next = 1'b0;
        end
        if (merge)
        begin
            out0_v_next = full | s2_last_reg;
            out0_next   = full ? res_full : res_flush;
            out1_v_next = full & s2_last_reg;
            out1_next   = res_flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            out0_v_reg  <= 1'b0;
            out1_v_reg  <= 1'b0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            emitted_reg <= '0;
            limit_reg   <= '1;
        end
        else
        begin
            if (s1_ready)
                s1_v_reg <= item_valid;
            if (s2_ready)
                s2_v_reg <= s1_v_reg;
            out0_v_reg  <= out0_v_next;
            out1_v_reg  <= out1_v_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            emitted_reg <= emitted_next;
            if (cfg_write && paddr[ADDR_W-1:2] == REG_DST_LIMIT)
                limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && item_valid)
            s1_reg <= item;
        if (s2_ready && s1_v_reg)
        begin
            s2_pext_reg <= pext;
            s2_cnt_reg  <= sel_cnt;
            s2_last_reg <= s1_reg.last_item;
        end
        out0_reg <= out0_next;
        out1_reg <= out1_next;
    end

endmodule

// ===== rtl/bsc_checker.sv =====
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the bit stream compactor, bound to the top level.
// ----------------------------------------------------------------------------
module bsc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       result_valid,
    input  logic                       result_stall,
    input  bsc_pkg::result_t           result
);
    import bsc_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // only the flush word can be partial
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_word |-> result.word_bits == 7'(WORD_BITS))
        else $error("non-final result is not a full word");

    // bits above the count are zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.word_bits != 7'(WORD_BITS)
            |-> (result.packed_word >> result.word_bits) == '0)
        else $error("unused high bits not zero");

    // running total covers the word
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.total_bits >= COUNT_BITS'(result.word_bits))
        else $error("total below word bit count");

endmodule

bind bit_stream_compactor bsc_checker u_bsc_checker (.*);
